>>> src/bit_plane_greedy_rectangle_merge_unit_defines.svh
// Assertion macros shared by the merge unit.
`ifndef BIT_PLANE_GREEDY_RECTANGLE_MERGE_UNIT_DEFINES_SVH
`define BIT_PLANE_GREEDY_RECTANGLE_MERGE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Check that the consequent follows the antecedent in the same cycle.
`define BPGRM_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Check that an expression holds at every edge out of reset.
`define BPGRM_ASSERT_HOLDS(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error(msg);

`else

`define BPGRM_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define BPGRM_ASSERT_HOLDS(lbl, clk, rstn, expr, msg)

`endif

`endif

>>> src/bpgrm_pkg.sv
package bpgrm_pkg;

  localparam int PLANE_WIDTH_DEF = 64;
  localparam int PLANE_ROWS_DEF  = 64;

  // Fixed port widths
  localparam int ROW_BITS_W = 64;
  localparam int COL_W      = 6;
  localparam int ROW_W      = 6;
  localparam int CSPAN_W    = 7;
  localparam int RSPAN_W    = 7;

  // Item kinds
  localparam logic KIND_ROW   = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic load;      // take the input item
    logic scan_rd;   // pick next open rectangle, read its entry
    logic scan_chk;  // grow, close or emit the rectangle just read
    logic open_run;  // open a rectangle on the leftmost leftover run
    logic finish;    // release the last result, advance or clear the plane
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic flush;        // item in work is a flush
    logic full;         // plane has all its rows
    logic work_any;     // open rectangles left to visit
    logic run_any;      // leftover set bits remain
    logic chk_blocked;  // a result must leave but the output is busy
    logic fin_blocked;  // last result cannot leave yet
  } sts_t;

endpackage

>>> src/bpgrm_ram.sv
module bpgrm_ram
  import bpgrm_pkg::*;
#(
  parameter int WIDTH = CSPAN_W + ROW_W,
  parameter int DEPTH = PLANE_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/bpgrm_ctrl.sv
module bpgrm_ctrl
  import bpgrm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_kind,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SCAN_RD = 3'd1;
  localparam logic [2:0] ST_SCAN_CK = 3'd2;
  localparam logic [2:0] ST_OPEN    = 3'd3;
  localparam logic [2:0] ST_FINISH  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        // drop a row that arrives after the plane is full
        if (in_valid && (in_kind == KIND_FLUSH || !sts.full)) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (sts.work_any) begin
          cmd.scan_rd = 1'b1;
          state_nxt   = ST_SCAN_CK;
        end else if (sts.flush) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_OPEN;
        end
      end
      ST_SCAN_CK: begin
        if (!sts.chk_blocked) begin
          cmd.scan_chk = 1'b1;
          state_nxt    = ST_SCAN_RD;
        end
      end
      ST_OPEN: begin
        if (sts.run_any) begin
          cmd.open_run = 1'b1;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!sts.fin_blocked) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/bpgrm_dp.sv
`include "bit_plane_greedy_rectangle_merge_unit_defines.svh"

module bpgrm_dp
  import bpgrm_pkg::*;
#(
  parameter int PLANE_WIDTH = PLANE_WIDTH_DEF,
  parameter int PLANE_ROWS  = PLANE_ROWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  in_kind,
  input  logic [ROW_BITS_W-1:0] in_row_bits,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [COL_W-1:0]      out_col_start,
  output logic [ROW_W-1:0]      out_row_start,
  output logic [CSPAN_W-1:0]    out_col_span,
  output logic [RSPAN_W-1:0]    out_row_span,
  output logic                  out_final_of_run
);

  localparam int W      = PLANE_WIDTH;
  localparam int CIDX_W = $clog2(PLANE_WIDTH);
  localparam int SPW    = $clog2(PLANE_WIDTH + 1);
  localparam int RS_W   = $clog2(PLANE_ROWS);
  localparam int CNT_W  = $clog2(PLANE_ROWS + 1);
  localparam int ENT_W  = SPW + RS_W;

  function automatic logic [CIDX_W-1:0] oh_idx(input logic [W-1:0] oh);
    logic [CIDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < W; i++) begin
      if (oh[i]) begin
        r = r | CIDX_W'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [SPW-1:0] oh_idx_end(input logic [W:0] oh);
    logic [SPW-1:0] r;
    r = '0;
    for (int i = 0; i <= W; i++) begin
      if (oh[i]) begin
        r = r | SPW'(i);
      end
    end
    return r;
  endfunction

  // Control state
  logic [W-1:0]     open_map_r, open_map_nxt;
  logic [CNT_W-1:0] rows_seen_r, rows_seen_nxt;
  logic             hold_vld_r, hold_vld_nxt;
  logic             out_vld_r, out_vld_nxt;

  // Payload
  logic [W-1:0]      work_r, work_nxt;
  logic [W-1:0]      row_r, row_nxt;
  logic              flush_r, flush_nxt;
  logic [CIDX_W-1:0] col_r, col_nxt;
  logic [CIDX_W-1:0] hold_col_r, hold_col_nxt;
  logic [RS_W-1:0]   hold_row_r, hold_row_nxt;
  logic [SPW-1:0]    hold_cspan_r, hold_cspan_nxt;
  logic [CNT_W-1:0]  hold_rspan_r, hold_rspan_nxt;
  logic [CIDX_W-1:0] out_col_r, out_col_nxt;
  logic [RS_W-1:0]   out_row_r, out_row_nxt;
  logic [SPW-1:0]    out_cspan_r, out_cspan_nxt;
  logic [CNT_W-1:0]  out_rspan_r, out_rspan_nxt;
  logic              out_final_r, out_final_nxt;

  logic [W-1:0]      row_in;
  logic [W-1:0]      scan_low;
  logic [CIDX_W-1:0] scan_col;
  logic [ENT_W-1:0]  rd_ent;
  logic [SPW-1:0]    rd_span;
  logic [RS_W-1:0]   rd_row;
  logic [W:0]        lo_oh, hi_oh, mask_full;
  logic [SPW:0]      end_sum;
  logic [SPW-1:0]    end_col;
  logic [W-1:0]      mask;
  logic              fits;
  logic              need_emit;
  logic              can_push;
  logic              push;
  logic [W-1:0]      run_low;
  logic [W:0]        run_sum;
  logic [W-1:0]      run_mask;
  logic [CIDX_W-1:0] run_start;
  logic [SPW-1:0]    run_end;
  logic [SPW-1:0]    run_span;
  logic [ENT_W-1:0]  wr_ent;
  logic [CNT_W-1:0]  rspan_now;

  // Column c sits at bit c internally; columns past the width drop out.
  always_comb begin
    for (int c = 0; c < W; c++) begin
      row_in[c] = in_row_bits[ROW_BITS_W-1-c];
    end
  end

  assign scan_low = work_r & (~work_r + W'(1));
  assign scan_col = oh_idx(scan_low);

  assign rd_span = rd_ent[ENT_W-1:RS_W];
  assign rd_row  = rd_ent[RS_W-1:0];

  // Mask of the rectangle's columns from two decoded edges
  assign lo_oh     = (W + 1)'(1) << col_r;
  assign end_sum   = (SPW + 1)'(col_r) + (SPW + 1)'(rd_span);
  assign end_col   = (end_sum > (SPW + 1)'(W)) ? SPW'(W) : end_sum[SPW-1:0];
  assign hi_oh     = (W + 1)'(1) << end_col;
  assign mask_full = hi_oh - lo_oh;
  assign mask      = mask_full[W-1:0];
  assign fits      = ((row_r & mask) == mask);
  assign need_emit = flush_r || !fits;
  assign rspan_now = rows_seen_r - CNT_W'(rd_row);

  // Leftmost leftover run: the carry of x + lowbit clears the run
  assign run_low   = row_r & (~row_r + W'(1));
  assign run_sum   = {1'b0, row_r} + {1'b0, run_low};
  assign run_mask  = row_r & ~run_sum[W-1:0];
  assign run_start = oh_idx(run_low);
  assign run_end   = oh_idx_end(run_sum & ~{1'b0, row_r});
  assign run_span  = run_end - SPW'(run_start);
  assign wr_ent    = {run_span, rows_seen_r[RS_W-1:0]};

  assign can_push = !out_vld_r || !out_stall;
  assign push     = hold_vld_r && ((cmd.scan_chk && need_emit) || cmd.finish);

  assign sts.flush       = flush_r;
  assign sts.full        = (rows_seen_r >= CNT_W'(PLANE_ROWS));
  assign sts.work_any    = |work_r;
  assign sts.run_any     = |row_r;
  assign sts.chk_blocked = need_emit && hold_vld_r && !can_push;
  assign sts.fin_blocked = hold_vld_r && !can_push;

  bpgrm_ram #(
    .WIDTH(ENT_W),
    .DEPTH(PLANE_WIDTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.open_run),
    .waddr(run_start),
    .wdata(wr_ent),
    .re   (cmd.scan_rd),
    .raddr(scan_col),
    .rdata(rd_ent)
  );

  always_comb begin
    open_map_nxt   = open_map_r;
    rows_seen_nxt  = rows_seen_r;
    hold_vld_nxt   = hold_vld_r;
    out_vld_nxt    = out_vld_r && out_stall;
    work_nxt       = work_r;
    row_nxt        = row_r;
    flush_nxt      = flush_r;
    col_nxt        = col_r;
    hold_col_nxt   = hold_col_r;
    hold_row_nxt   = hold_row_r;
    hold_cspan_nxt = hold_cspan_r;
    hold_rspan_nxt = hold_rspan_r;
    out_col_nxt    = out_col_r;
    out_row_nxt    = out_row_r;
    out_cspan_nxt  = out_cspan_r;
    out_rspan_nxt  = out_rspan_r;
    out_final_nxt  = out_final_r;

    // Move the held result out; it is final only at the item's end
    if (push) begin
      out_vld_nxt   = 1'b1;
      out_col_nxt   = hold_col_r;
      out_row_nxt   = hold_row_r;
      out_cspan_nxt = hold_cspan_r;
      out_rspan_nxt = hold_rspan_r;
      out_final_nxt = cmd.finish;
    end

    if (cmd.load) begin
      flush_nxt = in_kind;
      work_nxt  = open_map_r;
      row_nxt   = (in_kind == KIND_FLUSH) ? '0 : row_in;
    end

    if (cmd.scan_rd) begin
      col_nxt  = scan_col;
      work_nxt = work_r & ~scan_low;
    end

    if (cmd.scan_chk) begin
      if (!flush_r) begin
        if (fits) begin
          row_nxt = row_r & ~mask;
        end else begin
          open_map_nxt = open_map_r & ~lo_oh[W-1:0];
        end
      end
      if (need_emit) begin
        hold_vld_nxt   = 1'b1;
        hold_col_nxt   = col_r;
        hold_row_nxt   = rd_row;
        hold_cspan_nxt = rd_span;
        hold_rspan_nxt = rspan_now;
      end
    end

    if (cmd.open_run) begin
      open_map_nxt = open_map_r | run_low;
      row_nxt      = row_r & ~run_mask;
    end

    if (cmd.finish) begin
      hold_vld_nxt = 1'b0;
      if (flush_r) begin
        open_map_nxt  = '0;
        rows_seen_nxt = '0;
      end else begin
        rows_seen_nxt = rows_seen_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_map_r  <= '0;
      rows_seen_r <= '0;
      hold_vld_r  <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      open_map_r  <= open_map_nxt;
      rows_seen_r <= rows_seen_nxt;
      hold_vld_r  <= hold_vld_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r       <= work_nxt;
    row_r        <= row_nxt;
    flush_r      <= flush_nxt;
    col_r        <= col_nxt;
    hold_col_r   <= hold_col_nxt;
    hold_row_r   <= hold_row_nxt;
    hold_cspan_r <= hold_cspan_nxt;
    hold_rspan_r <= hold_rspan_nxt;
    out_col_r    <= out_col_nxt;
    out_row_r    <= out_row_nxt;
    out_cspan_r  <= out_cspan_nxt;
    out_rspan_r  <= out_rspan_nxt;
    out_final_r  <= out_final_nxt;
  end

  assign out_valid        = out_vld_r;
  assign out_col_start    = COL_W'(out_col_r);
  assign out_row_start    = ROW_W'(out_row_r);
  assign out_col_span     = CSPAN_W'(out_cspan_r);
  assign out_row_span     = RSPAN_W'(out_rspan_r);
  assign out_final_of_run = out_final_r;

  `BPGRM_ASSERT_IMPLY(a_push_room, clk, rst_n, push, can_push, "result pushed onto busy output")
  `BPGRM_ASSERT_IMPLY(a_open_fresh, clk, rst_n, cmd.open_run, (open_map_r & run_low) == '0, "new run starts on an open rectangle")
  `BPGRM_ASSERT_IMPLY(a_row_full_stop, clk, rst_n, cmd.load && !in_kind, rows_seen_r < CNT_W'(PLANE_ROWS), "row taken past the plane")
  `BPGRM_ASSERT_HOLDS(a_rows_bound, clk, rst_n, rows_seen_r <= CNT_W'(PLANE_ROWS), "row count beyond plane")

endmodule

>>> src/bit_plane_greedy_rectangle_merge_unit.sv
// Flow: a row item runs the open-rectangle scan and the run opener before the next item can
//   transfer; a flush skips the run opener; a row arriving while the plane is full is dropped.
// Throughput: one item at a time; the open-rectangle scan (one RAM read, one check per
//   rectangle) and the run opener (one RAM write per run) set the rate; output stalls add.
// Reset: synchronous, active low; clears the open map, row count and result valids.
//   The rectangle RAM is not cleared; an entry is read only after it is written.
module bit_plane_greedy_rectangle_merge_unit
  import bpgrm_pkg::*;
#(
  parameter int PLANE_WIDTH = PLANE_WIDTH_DEF,
  parameter int PLANE_ROWS  = PLANE_ROWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  logic [ROW_BITS_W-1:0] in_row_bits,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COL_W-1:0]      out_col_start,
  output logic [ROW_W-1:0]      out_row_start,
  output logic [CSPAN_W-1:0]    out_col_span,
  output logic [RSPAN_W-1:0]    out_row_span,
  output logic                  out_final_of_run
);

  // The controller sequences each item through these phases:
  //   take the item, visit every open rectangle in ascending column (read its
  //   start row and width from the RAM, then grow it over the new row or close
  //   it), open one rectangle per leftover run, and finish the item.
  // Closed rectangles wait in a one-entry hold slot so the last result of an
  // item can be marked final once the item ends; the output register keeps a
  // finished transfer waiting while the next item is taken.
  cmd_t cmd;
  sts_t sts;

  bpgrm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_kind (in_kind),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  // The datapath holds the open map, the row count, the rectangle RAM and
  // the output register.
  bpgrm_dp #(
    .PLANE_WIDTH(PLANE_WIDTH),
    .PLANE_ROWS (PLANE_ROWS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (in_kind),
    .in_row_bits     (in_row_bits),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_col_start   (out_col_start),
    .out_row_start   (out_row_start),
    .out_col_span    (out_col_span),
    .out_row_span    (out_row_span),
    .out_final_of_run(out_final_of_run)
  );

endmodule
